FILE: hw/rtl/oqrbv_pkg.sv
`default_nettype none

package oqrbv_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int VAL_W     = 32;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_DUMP   = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_EMPTY    = 2'd3
  } status_t;

  typedef enum logic {
    FSM_IDLE,
    FSM_DUMP
  } fsm_t;

  // Per-cycle operation broadcast to every cell of the chain.
  typedef struct packed {
    logic ins;
    logic rem;
    logic rot;
  } cell_ctl_t;

endpackage

`default_nettype wire

FILE: hw/rtl/oqrbv_cell.sv
`default_nettype none

module oqrbv_cell #(
  parameter int DEPTH = oqrbv_pkg::DEPTH_DEF,
  parameter int IDX   = 0,
  localparam int CW   = $clog2(DEPTH + 1)
) (
  input  wire logic                           clk,
  input  wire oqrbv_pkg::cell_ctl_t           ctl,
  input  wire logic [CW-1:0]                  count,
  input  wire logic [oqrbv_pkg::VAL_W-1:0]    key,
  input  wire logic [oqrbv_pkg::VAL_W-1:0]    head_data,
  input  wire logic [oqrbv_pkg::VAL_W-1:0]    right_data,
  input  wire logic                           match_in,
  output logic      [oqrbv_pkg::VAL_W-1:0]    data_out,
  output logic                                match_out
);

  logic [oqrbv_pkg::VAL_W-1:0] data_r;
  logic [oqrbv_pkg::VAL_W-1:0] data_nxt;
  logic                        occupied;
  logic                        own_match;

  assign occupied  = count > CW'(IDX);
  assign own_match = occupied && (data_r == key);
  // Once a match is seen at or ahead of this cell, this cell pulls from its right.
  assign match_out = match_in || own_match;
  assign data_out  = data_r;

  always_comb begin
    data_nxt = data_r;
    if (ctl.ins && (count == CW'(IDX))) begin
      data_nxt = key;
    end else if (ctl.rem && match_out) begin
      data_nxt = right_data;
    end else if (ctl.rot) begin
      // The tail cell takes the head so the contents rotate within the occupied part.
      data_nxt = (count == CW'(IDX + 1)) ? head_data : right_data;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

endmodule

`default_nettype wire

FILE: hw/rtl/ordered_queue_remove_by_value.sv
// Ordered queue of signed 32-bit values with insert, remove-by-value and dump.
// Input channel: in_tuser carries the command (insert, remove, dump), in_tdata the
// value. Result channel: out_tuser carries status and entry_valid, out_tdata the
// entry and the occupancy after the command, out_tlast marks the final result.
// The entries sit in a chain of cells; every cell compares its value with the key
// in the same cycle and the cells behind the first match shift one place forward.
// Insert, remove and unused commands each give one registered result transfer
// in the cycle after acceptance; a new command is taken once that result is taken.
// A dump of N entries enters the dump state and rotates the chain once per cycle
// while the output is free, giving N results; no command is taken meanwhile.
// A dump of an empty queue gives a single result with status empty.
// Reset empties the queue and drops any pending result; entry storage is not
// cleared. When the receiver stalls, the result is held in the output register and
// in_tready stays low until it is taken, so nothing is lost or repeated.
`default_nettype none

module ordered_queue_remove_by_value #(
  parameter int DEPTH  = oqrbv_pkg::DEPTH_DEF,
  localparam int CW    = $clog2(DEPTH + 1),
  localparam int OUT_W = ((oqrbv_pkg::VAL_W + CW + 7) / 8) * 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [oqrbv_pkg::VAL_W-1:0]   in_tdata,   // [31:0] value
  input  wire logic [1:0]                    in_tuser,   // [1:0] cmd
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic      [OUT_W-1:0]              out_tdata,  // [31:0] entry, then occupancy
  output logic      [2:0]                    out_tuser,  // [1:0] status, [2] entry_valid
  output logic                               out_tlast
);

  localparam int PAD_W = OUT_W - oqrbv_pkg::VAL_W - CW;

  oqrbv_pkg::fsm_t      state_r, state_nxt;
  logic [CW-1:0]        count_r, count_nxt;
  logic [CW-1:0]        idx_r, idx_nxt;
  logic                 out_valid_r, out_valid_nxt;
  oqrbv_pkg::status_t   status_r, status_nxt;
  logic [oqrbv_pkg::VAL_W-1:0] entry_r, entry_nxt;
  logic                 ev_r, ev_nxt;
  logic                 last_r, last_nxt;
  logic [CW-1:0]        occ_r, occ_nxt;

  oqrbv_pkg::cell_ctl_t ctl;
  oqrbv_pkg::cmd_t      cmd;
  logic                 out_free;
  logic                 acc;
  logic                 full;
  logic                 found;
  logic                 dump_last;

  logic [oqrbv_pkg::VAL_W-1:0] cell_data [DEPTH];
  logic                        cell_match [DEPTH];

  assign cmd       = oqrbv_pkg::cmd_t'(in_tuser);
  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == oqrbv_pkg::FSM_IDLE) && out_free;
  assign acc       = in_tvalid && in_tready;
  assign full      = count_r == CW'(DEPTH);
  assign found     = cell_match[DEPTH-1];
  assign dump_last = idx_r == (count_r - CW'(1));

  assign ctl.ins = acc && (cmd == oqrbv_pkg::CMD_INSERT) && !full;
  assign ctl.rem = acc && (cmd == oqrbv_pkg::CMD_REMOVE);
  assign ctl.rot = (state_r == oqrbv_pkg::FSM_DUMP) && out_free;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [oqrbv_pkg::VAL_W-1:0] right;
    logic                        m_in;
    if (i == DEPTH - 1) begin : g_end
      assign right = cell_data[i];
    end else begin : g_mid
      assign right = cell_data[i+1];
    end
    if (i == 0) begin : g_head
      assign m_in = 1'b0;
    end else begin : g_body
      assign m_in = cell_match[i-1];
    end
    oqrbv_cell #(
      .DEPTH (DEPTH),
      .IDX   (i)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .count      (count_r),
      .key        (in_tdata),
      .head_data  (cell_data[0]),
      .right_data (right),
      .match_in   (m_in),
      .data_out   (cell_data[i]),
      .match_out  (cell_match[i])
    );
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r && !out_tready;
    status_nxt    = status_r;
    entry_nxt     = entry_r;
    ev_nxt        = ev_r;
    last_nxt      = last_r;
    occ_nxt       = occ_r;

    if (acc) begin
      status_nxt = oqrbv_pkg::ST_OK;
      entry_nxt  = '0;
      ev_nxt     = 1'b0;
      last_nxt   = 1'b1;
      case (cmd)
        oqrbv_pkg::CMD_INSERT: begin
          if (full) begin
            status_nxt = oqrbv_pkg::ST_FULL;
          end else begin
            count_nxt = count_r + CW'(1);
          end
        end
        oqrbv_pkg::CMD_REMOVE: begin
          if (found) begin
            count_nxt = count_r - CW'(1);
          end else begin
            status_nxt = oqrbv_pkg::ST_NOTFOUND;
          end
        end
        oqrbv_pkg::CMD_DUMP: begin
          if (count_r == '0) begin
            status_nxt = oqrbv_pkg::ST_EMPTY;
          end
        end
        default: begin
        end
      endcase
      occ_nxt = count_nxt;
      if ((cmd == oqrbv_pkg::CMD_DUMP) && (count_r != '0)) begin
        state_nxt = oqrbv_pkg::FSM_DUMP;
        idx_nxt   = '0;
      end else begin
        out_valid_nxt = 1'b1;
      end
    end else if (ctl.rot) begin
      // The head cell always holds the next entry to send while the chain rotates.
      out_valid_nxt = 1'b1;
      status_nxt    = oqrbv_pkg::ST_OK;
      entry_nxt     = cell_data[0];
      ev_nxt        = 1'b1;
      last_nxt      = dump_last;
      occ_nxt       = count_r;
      idx_nxt       = idx_r + CW'(1);
      if (dump_last) begin
        state_nxt = oqrbv_pkg::FSM_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= oqrbv_pkg::FSM_IDLE;
      count_r     <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    entry_r  <= entry_nxt;
    ev_r     <= ev_nxt;
    last_r   <= last_nxt;
    occ_r    <= occ_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{PAD_W{1'b0}}, occ_r, entry_r};
  assign out_tuser  = {ev_r, status_r};
  assign out_tlast  = last_r;

endmodule

`default_nettype wire

FILE: hw/rtl/oqrbv_checker.sv
`default_nettype none

module oqrbv_props #(
  parameter int DEPTH  = oqrbv_pkg::DEPTH_DEF,
  localparam int CW    = $clog2(DEPTH + 1),
  localparam int OUT_W = ((oqrbv_pkg::VAL_W + CW + 7) / 8) * 8
) (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        in_tready,
  input wire logic                        out_tvalid,
  input wire logic                        out_tready,
  input wire logic [OUT_W-1:0]            out_tdata,
  input wire logic [2:0]                  out_tuser,
  input wire logic                        out_tlast
);

  // A result that is not a dumped entry always closes its command.
  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser[2]) |-> out_tlast)
    else $error("non-entry result without tlast");

  a_entry_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser[2]) |-> (out_tdata[oqrbv_pkg::VAL_W-1:0] == '0))
    else $error("entry not zero on a non-entry result");

  // An empty dump reports an empty queue.
  a_empty_occ: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser[1:0] == oqrbv_pkg::ST_EMPTY))
      |-> (out_tdata[oqrbv_pkg::VAL_W +: CW] == '0))
    else $error("empty status with nonzero occupancy");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("stalled result changed");

  // A waiting result blocks the input side.
  a_in_block: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |-> !in_tready)
    else $error("input ready while a result is stalled");

endmodule

bind ordered_queue_remove_by_value oqrbv_props #(.DEPTH(DEPTH)) u_oqrbv_props (.*);

`default_nettype wire

FILE: tb/oqrbv_checker.sv
module oqrbv_checker
  import oqrbv_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF,
  parameter int OUT_W = 40
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_tvalid,
  input  wire logic               in_tready,
  input  wire logic [VAL_W-1:0]   in_tdata,
  input  wire logic [1:0]         in_tuser,
  input  wire logic               out_tvalid,
  input  wire logic               out_tready,
  input  wire logic [OUT_W-1:0]   out_tdata,
  input  wire logic [2:0]         out_tuser,
  input  wire logic               out_tlast,
  output int                      fail_count,
  output int                      pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW = $clog2(DEPTH + 1);

  typedef struct {
    status_t          status;
    logic [VAL_W-1:0] entry;
    logic             entry_valid;
    logic             last;
    logic [CW-1:0]    occupancy;
  } queue_result_t;

  // Our own copy of the queue, head at index 0.
  logic [VAL_W-1:0] held_values[$];
  queue_result_t    awaited_results[$];
  int               mismatch_count = 0;
  int               awaited_count = 0;

  assign fail_count = mismatch_count;
  assign pending    = awaited_count;

  function automatic void add_result(status_t st, logic [VAL_W-1:0] e, logic ev, logic lst);
    queue_result_t r;
    r.status      = st;
    r.entry       = e;
    r.entry_valid = ev;
    r.last        = lst;
    r.occupancy   = CW'(held_values.size());
    awaited_results.push_back(r);
  endfunction

  function automatic void apply_command(cmd_t cmd, logic [VAL_W-1:0] value);
    int hit;
    hit = -1;
    case (cmd)
      CMD_INSERT: begin
        if (held_values.size() >= DEPTH) begin
          add_result(ST_FULL, '0, 1'b0, 1'b1);
        end else begin
          held_values.push_back(value);
          add_result(ST_OK, '0, 1'b0, 1'b1);
        end
      end
      CMD_REMOVE: begin
        // Only the first match from the head goes; later duplicates stay.
        for (int k = 0; k < held_values.size(); k++) begin
          if (hit < 0 && held_values[k] == value) hit = k;
        end
        if (hit < 0) begin
          add_result(ST_NOTFOUND, '0, 1'b0, 1'b1);
        end else begin
          held_values.delete(hit);
          add_result(ST_OK, '0, 1'b0, 1'b1);
        end
      end
      CMD_DUMP: begin
        if (held_values.size() == 0) begin
          add_result(ST_EMPTY, '0, 1'b0, 1'b1);
        end else begin
          foreach (held_values[k])
            add_result(ST_OK, held_values[k], 1'b1, k == held_values.size() - 1);
        end
      end
      CMD_NOP: begin
        add_result(ST_OK, '0, 1'b0, 1'b1);
      end
    endcase
  endfunction

  always @(posedge clk) begin : monitor
    queue_result_t    want;
    logic [1:0]       got_status;
    logic [VAL_W-1:0] got_entry;
    logic [CW-1:0]    got_occupancy;
    if (!rst_n) begin
      held_values.delete();
      awaited_results.delete();
    end else begin
      if (in_tvalid && in_tready)
        apply_command(cmd_t'(in_tuser), in_tdata);
      if (out_tvalid && out_tready) begin
        got_status    = out_tuser[1:0];
        got_entry     = out_tdata[VAL_W-1:0];
        got_occupancy = out_tdata[VAL_W +: CW];
        if (awaited_results.size() == 0) begin
          $error("result transfer with nothing awaited: status %0d entry %0d",
                 got_status, $signed(got_entry));
          mismatch_count++;
        end else begin
          want = awaited_results.pop_front();
          if (got_status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got_status);
            mismatch_count++;
          end
          if (got_entry !== want.entry) begin
            $error("entry: expected %0d, got %0d", $signed(want.entry), $signed(got_entry));
            mismatch_count++;
          end
          if (out_tuser[2] !== want.entry_valid) begin
            $error("entry_valid: expected %0b, got %0b", want.entry_valid, out_tuser[2]);
            mismatch_count++;
          end
          if (out_tlast !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, out_tlast);
            mismatch_count++;
          end
          if (got_occupancy !== want.occupancy) begin
            $error("occupancy: expected %0d, got %0d", want.occupancy, got_occupancy);
            mismatch_count++;
          end
        end
      end
    end
    awaited_count = awaited_results.size();
  end

endmodule

FILE: tb/ordered_queue_remove_by_value_tb.sv
module ordered_queue_remove_by_value_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import oqrbv_pkg::*;

  localparam int DEPTH          = DEPTH_DEF;
  localparam int CW             = $clog2(DEPTH + 1);
  localparam int OUT_W          = ((VAL_W + CW + 7) / 8) * 8;
  localparam int HOLD_CYCLES    = 90;
  localparam int WATCHDOG_LIMIT = 2000;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [VAL_W-1:0] in_tdata = '0;
  logic [1:0]       in_tuser = '0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;
  logic [2:0]       out_tuser;
  logic             out_tlast;

  int   fail_count;
  int   pending;
  int   idle_cycles = 0;
  logic allow_gaps = 1'b1;
  logic hold_out = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  ordered_queue_remove_by_value #(.DEPTH(DEPTH)) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  oqrbv_checker #(.DEPTH(DEPTH), .OUT_W(OUT_W)) i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Receiver: random stall bursts, plus one long hold-off on request.
  initial begin : receiver
    int stall;
    forever begin
      if (hold_out) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_out = 1'b0;
      end else if (allow_gaps && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        stall = $urandom_range(1, 17);
        repeat (stall) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Called at a rising edge; returns at the edge where the transfer happened.
  // tvalid stays high on return so back-to-back items need no second assignment.
  task automatic send_cmd(input cmd_t cmd, input logic [VAL_W-1:0] value);
    int gap;
    if (allow_gaps && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 17);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= value;
    do @(negedge clk); while (!in_tready);
    @(posedge clk);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  initial begin : stimulus
    logic [VAL_W-1:0] value_pool[8];
    logic [VAL_W-1:0] value;
    cmd_t             cmd;
    int               insert_odds;
    int               pick;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty-queue cases, the unused code, extreme values, duplicates.
    send_cmd(CMD_DUMP, 32'h0000_0000);
    send_cmd(CMD_REMOVE, 32'h0000_0007);
    send_cmd(CMD_NOP, $urandom());
    send_cmd(CMD_INSERT, 32'h8000_0000);
    send_cmd(CMD_INSERT, 32'h7FFF_FFFF);
    send_cmd(CMD_INSERT, 32'h0000_0000);
    send_cmd(CMD_INSERT, 32'hFFFF_FFFF);
    send_cmd(CMD_INSERT, 32'h0000_0005);
    send_cmd(CMD_INSERT, 32'h0000_0005);
    send_cmd(CMD_DUMP, 32'hFFFF_FFFF);
    send_cmd(CMD_REMOVE, 32'h0000_007B);
    send_cmd(CMD_REMOVE, 32'h0000_0005);
    send_cmd(CMD_REMOVE, 32'h8000_0000);
    send_cmd(CMD_REMOVE, 32'h0000_0005);
    for (int k = 0; k < DEPTH - 3; k++)
      send_cmd(CMD_INSERT, $urandom());
    send_cmd(CMD_INSERT, 32'h1234_5678);
    send_cmd(CMD_DUMP, 32'h0000_0000);
    send_cmd(CMD_REMOVE, 32'h0000_0000);
    send_cmd(CMD_NOP, 32'hFFFF_FFFF);

    // Random phases. A small value pool makes removes hit and duplicates common;
    // the insert share varies per phase so the queue swings between empty and full.
    for (int phase = 0; phase < 8; phase++) begin
      insert_odds = $urandom_range(20, 75);
      allow_gaps  = (phase != 7) && ($urandom_range(0, 3) != 0);
      foreach (value_pool[k]) value_pool[k] = $urandom();
      for (int n = 0; n < 60; n++) begin
        pick  = $urandom_range(0, 99);
        value = ($urandom_range(0, 3) == 0) ? $urandom() : value_pool[$urandom_range(0, 7)];
        if (pick < insert_odds)
          cmd = CMD_INSERT;
        else if (pick < 86)
          cmd = CMD_REMOVE;
        else if (pick < 97)
          cmd = CMD_DUMP;
        else
          cmd = CMD_NOP;
        if (phase == 1 && n == 20)
          hold_out = 1'b1;
        send_cmd(cmd, value);
      end
      if (phase == 3)
        wait_drained();
    end

    wait_drained();
    repeat (8) @(negedge clk);
    if (fail_count == 0 && pending == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
